>>> rtl/core/plane_offset_and_tilt_defines.svh
// assertion macros for the plane offset and tilt block
// used by the port checker; depends on a clock and reset in scope
`ifndef PLANE_OFFSET_AND_TILT_DEFINES_SVH
`define PLANE_OFFSET_AND_TILT_DEFINES_SVH

// implication checked in the same cycle
`define POT_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// plain invariant
`define POT_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

`endif

>>> rtl/core/pot_pkg.sv
// shared types, constants and helpers of the plane offset and tilt block
// no dependencies
package pot_pkg;

   localparam int COORD_W      = 32;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int TILT_W       = 24;
   localparam int SID_W        = 9;
   localparam int NORM_W       = 56;
   localparam int CORDIC_W     = 60;
   localparam int ANG_W        = 33;
   localparam int CORDIC_STEPS = 28;
   localparam int NORM_STAGES  = 3;
   localparam int TILT_LAT     = 1 + NORM_STAGES + CORDIC_STEPS + 1;
   localparam int PIPE_LATENCY = 1 + TILT_LAT;

   localparam logic signed [TILT_W-1:0] RIGHT_ANGLE_Q16 = 24'sd5898240;
   localparam logic signed [ANG_W-1:0]  RIGHT_ANGLE_Q24 = 33'sd1509949440;
   localparam logic signed [ANG_W-1:0]  ROUND_HALF      = 33'sd128;

   // arctan(2^-i) in degrees q.24
   localparam logic signed [ANG_W-1:0] ANGLE_TBL [CORDIC_STEPS] = '{
      33'sd754974720, 33'sd445687602, 33'sd235489088, 33'sd119537938,
      33'sd60000934,  33'sd30029717,  33'sd15018523,  33'sd7509720,
      33'sd3754917,   33'sd1877466,   33'sd938734,    33'sd469367,
      33'sd234684,    33'sd117342,    33'sd58671,     33'sd29335,
      33'sd14668,     33'sd7334,      33'sd3667,      33'sd1833,
      33'sd917,       33'sd458,       33'sd229,       33'sd115,
      33'sd57,        33'sd29,        33'sd14,        33'sd7
   };

   // two normalising shift steps per stage
   localparam int NORM_SHIFT [2*NORM_STAGES] = '{32, 16, 8, 4, 2, 1};

   typedef enum logic [0:0] {
      CSR_DUT_POSITION = 1'b0,
      CSR_DUT_ID       = 1'b1
   } pot_csr_type;

   typedef struct packed {
      logic [3:0]                plane_index;
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic signed [COORD_W-1:0] first_z;
      logic signed [COORD_W-1:0] second_x;
      logic signed [COORD_W-1:0] second_y;
      logic signed [COORD_W-1:0] second_z;
      logic signed [COORD_W-1:0] third_y;
      logic signed [COORD_W-1:0] third_z;
   } pot_req_type;

   typedef struct packed {
      logic signed [SID_W-1:0]   sensor_id;
      logic                      is_dut;
      logic signed [COORD_W-1:0] x_offset;
      logic signed [COORD_W-1:0] y_offset;
      logic signed [COORD_W-1:0] z_offset;
      logic signed [TILT_W-1:0]  alpha_tilt;
      logic signed [TILT_W-1:0]  beta_tilt;
      logic signed [TILT_W-1:0]  gamma_tilt;
      logic                      degenerate;
   } pot_rsp_type;

   // word fields that do not pass through the arctangent pipes
   typedef struct packed {
      logic signed [SID_W-1:0]   sensor_id;
      logic                      is_dut;
      logic signed [COORD_W-1:0] x_offset;
      logic signed [COORD_W-1:0] y_offset;
      logic signed [COORD_W-1:0] z_offset;
   } pot_side_type;

   // special-case flags travelling beside one cordic pipe
   typedef struct packed {
      logic                     byp;
      logic                     neg;
      logic                     degen;
      logic signed [TILT_W-1:0] val;
   } pot_tside_type;

   function automatic logic signed [DIFF_W:0] sext2(input logic signed [COORD_W-1:0] v);
      return $signed({{2{v[COORD_W-1]}}, v});
   endfunction

   function automatic logic signed [DIFF_W-1:0] diff(input logic signed [COORD_W-1:0] a,
                                                    input logic signed [COORD_W-1:0] b);
      logic signed [DIFF_W:0] d;
      d = sext2(a) - sext2(b);
      return d[DIFF_W-1:0];
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [DIFF_W:0] v);
      logic signed [DIFF_W:0] hi;
      logic signed [DIFF_W:0] lo;
      hi = $signed({2'b00, 1'b0, {(COORD_W-1){1'b1}}});
      lo = $signed({2'b11, 1'b1, {(COORD_W-1){1'b0}}});
      if (v > hi) begin
         return hi[COORD_W-1:0];
      end else if (v < lo) begin
         return lo[COORD_W-1:0];
      end
      return v[COORD_W-1:0];
   endfunction

endpackage

>>> rtl/core/plane_offset_and_tilt.sv
// plane offset and tilt: accepts one word per cycle, each result shown with rsp_strobe
// three parallel 28-stage cordic pipes, each behind its own 3-stage normaliser
// busy follows reset, so no word is taken while reset is high; afterwards always ready
// reset is synchronous, active high: clears the valid line and csr registers to 3 and 6
// depends on pot_pkg and pot_tilt
module plane_offset_and_tilt
   import pot_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  pot_req_type req_word,
   output logic        rsp_strobe,
   output pot_rsp_type rsp_word,
   input  logic        csr_we,
   input  pot_csr_type csr_index,
   input  logic [7:0]  csr_data
);

   // csr registers
   logic [3:0] dut_position_ff;
   logic [7:0] dut_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dut_position_ff <= 4'd3;
         dut_id_ff       <= 8'd6;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DUT_POSITION: dut_position_ff <= csr_data[3:0];
            CSR_DUT_ID:       dut_id_ff       <= csr_data;
         endcase
      end
   end

   // the pipe never stalls: only reset holds words off
   logic accept;
   assign busy   = reset;
   assign accept = start & ~busy;

   // first stage: coordinate differences, offsets and sensor id
   pot_side_type             side_a_in, side_a_ff;
   logic                     valid_a_ff;
   logic signed [DIFF_W-1:0] dz02_ff, dy02_ff, dz01_ff, dx01_ff, dy01_ff;
   logic signed [DIFF_W:0]   nx_sum, ny_sum, dz_full;
   logic                     is_dut;

   always_comb begin
      nx_sum  = -(sext2(req_word.first_x) + sext2(req_word.second_x));
      ny_sum  = -(sext2(req_word.first_y) + sext2(req_word.third_y));
      dz_full = sext2(req_word.first_z) - sext2(req_word.third_z);
      is_dut  = (req_word.plane_index == dut_position_ff);

      side_a_in.is_dut   = is_dut;
      side_a_in.x_offset = sat_coord(nx_sum >>> 1);
      side_a_in.y_offset = sat_coord(ny_sum >>> 1);
      side_a_in.z_offset = sat_coord(dz_full >>> 1);

      // priority: plane indices above 3, then the dut, then indices below 3
      if (req_word.plane_index > 4'd3) begin
         side_a_in.sensor_id = $signed({5'b0, req_word.plane_index} - 9'd1);
      end else if (is_dut) begin
         side_a_in.sensor_id = $signed({1'b0, dut_id_ff});
      end else if (req_word.plane_index < 4'd3) begin
         side_a_in.sensor_id = $signed({5'b0, req_word.plane_index});
      end else begin
         side_a_in.sensor_id = -9'sd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      side_a_ff <= side_a_in;
      dz02_ff   <= diff(req_word.first_z, req_word.third_z);
      dy02_ff   <= diff(req_word.first_y, req_word.third_y);
      dz01_ff   <= diff(req_word.first_z, req_word.second_z);
      dx01_ff   <= diff(req_word.first_x, req_word.second_x);
      dy01_ff   <= diff(req_word.first_y, req_word.second_y);
   end

   // three arctangent channels
   logic signed [TILT_W-1:0] alpha, beta, gamma;
   logic                     deg_a, deg_b, deg_g;

   pot_tilt u_alpha (
      .clock   (clock),
      .num_i   (dz02_ff),
      .den_i   (dy02_ff),
      .tilt_o  (alpha),
      .degen_o (deg_a)
   );

   pot_tilt u_beta (
      .clock   (clock),
      .num_i   (dz01_ff),
      .den_i   (dx01_ff),
      .tilt_o  (beta),
      .degen_o (deg_b)
   );

   pot_tilt u_gamma (
      .clock   (clock),
      .num_i   (dy01_ff),
      .den_i   (dx01_ff),
      .tilt_o  (gamma),
      .degen_o (deg_g)
   );

   // delay line keeping the side fields and valid bit level with the tilt pipes
   pot_side_type side_ff  [TILT_LAT];
   logic         valid_ff [TILT_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TILT_LAT; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= valid_a_ff;
         for (int k = 1; k < TILT_LAT; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_a_ff;
      for (int k = 1; k < TILT_LAT; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   // result word, fields from registers; degenerate is the OR of the three channel flags
   assign rsp_strobe          = valid_ff[TILT_LAT-1];
   assign rsp_word.sensor_id  = side_ff[TILT_LAT-1].sensor_id;
   assign rsp_word.is_dut     = side_ff[TILT_LAT-1].is_dut;
   assign rsp_word.x_offset   = side_ff[TILT_LAT-1].x_offset;
   assign rsp_word.y_offset   = side_ff[TILT_LAT-1].y_offset;
   assign rsp_word.z_offset   = side_ff[TILT_LAT-1].z_offset;
   assign rsp_word.alpha_tilt = alpha;
   assign rsp_word.beta_tilt  = beta;
   assign rsp_word.gamma_tilt = gamma;
   assign rsp_word.degenerate = deg_a | deg_b | deg_g;

endmodule

>>> rtl/core/pot_norm.sv
// normalising shifter: moves a magnitude pair up until the larger lies in [2^55, 2^56)
// depends on pot_pkg
module pot_norm
   import pot_pkg::*;
(
   input  logic              clock,
   input  logic [NORM_W-1:0] x_i,
   input  logic [NORM_W-1:0] y_i,
   output logic [NORM_W-1:0] x_o,
   output logic [NORM_W-1:0] y_o
);

   logic [NORM_W-1:0] src_x [NORM_STAGES];
   logic [NORM_W-1:0] src_y [NORM_STAGES];
   logic [NORM_W-1:0] x_in  [NORM_STAGES];
   logic [NORM_W-1:0] y_in  [NORM_STAGES];
   logic [NORM_W-1:0] x_ff  [NORM_STAGES];
   logic [NORM_W-1:0] y_ff  [NORM_STAGES];

   always_comb begin
      logic [NORM_W-1:0] xt;
      logic [NORM_W-1:0] yt;
      src_x[0] = x_i;
      src_y[0] = y_i;
      for (int s = 1; s < NORM_STAGES; s++) begin
         src_x[s] = x_ff[s-1];
         src_y[s] = y_ff[s-1];
      end
      for (int s = 0; s < NORM_STAGES; s++) begin
         xt = src_x[s];
         yt = src_y[s];
         for (int j = 0; j < 2; j++) begin
            if (((xt | yt) >> (NORM_W - NORM_SHIFT[2*s+j])) == '0) begin
               xt = xt << NORM_SHIFT[2*s+j];
               yt = yt << NORM_SHIFT[2*s+j];
            end
         end
         x_in[s] = xt;
         y_in[s] = yt;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NORM_STAGES; s++) begin
         x_ff[s] <= x_in[s];
         y_ff[s] <= y_in[s];
      end
   end

   assign x_o = x_ff[NORM_STAGES-1];
   assign y_o = y_ff[NORM_STAGES-1];

endmodule

>>> rtl/core/pot_cordic.sv
// vectoring cordic, one rotation per register stage, angle out in degrees q.24
// depends on pot_pkg
module pot_cordic
   import pot_pkg::*;
(
   input  logic                    clock,
   input  logic [NORM_W-1:0]       x_i,
   input  logic [NORM_W-1:0]       y_i,
   output logic signed [ANG_W-1:0] z_o
);

   logic signed [CORDIC_W-1:0] src_x [CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] src_y [CORDIC_STEPS];
   logic signed [ANG_W-1:0]    src_z [CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] x_in  [CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] y_in  [CORDIC_STEPS];
   logic signed [ANG_W-1:0]    z_in  [CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] x_ff  [CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] y_ff  [CORDIC_STEPS];
   logic signed [ANG_W-1:0]    z_ff  [CORDIC_STEPS];

   always_comb begin
      src_x[0] = $signed({{(CORDIC_W-NORM_W){1'b0}}, x_i});
      src_y[0] = $signed({{(CORDIC_W-NORM_W){1'b0}}, y_i});
      src_z[0] = '0;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
         src_x[i] = x_ff[i-1];
         src_y[i] = y_ff[i-1];
         src_z[i] = z_ff[i-1];
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (!src_y[i][CORDIC_W-1]) begin
            x_in[i] = src_x[i] + (src_y[i] >>> i);
            y_in[i] = src_y[i] - (src_x[i] >>> i);
            z_in[i] = src_z[i] + ANGLE_TBL[i];
         end else begin
            x_in[i] = src_x[i] - (src_y[i] >>> i);
            y_in[i] = src_y[i] + (src_x[i] >>> i);
            z_in[i] = src_z[i] - ANGLE_TBL[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         x_ff[i] <= x_in[i];
         y_ff[i] <= y_in[i];
         z_ff[i] <= z_in[i];
      end
   end

   assign z_o = z_ff[CORDIC_STEPS-1];

endmodule

>>> rtl/core/pot_tilt.sv
// one tilt channel: negated atan(num / den) in degrees q.16 with special cases
// depends on pot_pkg, pot_norm, pot_cordic
module pot_tilt
   import pot_pkg::*;
(
   input  logic                     clock,
   input  logic signed [DIFF_W-1:0] num_i,
   input  logic signed [DIFF_W-1:0] den_i,
   output logic signed [TILT_W-1:0] tilt_o,
   output logic                     degen_o
);

   localparam int SIDE_DEPTH = NORM_STAGES + CORDIC_STEPS + 1;

   logic              num_zero, den_zero, num_neg, den_neg;
   logic [DIFF_W-1:0] an, ad;
   logic [NORM_W-1:0] ax_ff, ay_ff, nx, ny;
   pot_tside_type     side_in;
   pot_tside_type     side_ff [SIDE_DEPTH];
   logic signed [ANG_W-1:0]  z, zc, zr;
   logic signed [TILT_W-1:0] mag;
   logic signed [TILT_W-1:0] tilt_in, tilt_ff;
   logic                     degen_ff;

   always_comb begin
      num_zero      = (num_i == '0);
      den_zero      = (den_i == '0);
      num_neg       = num_i[DIFF_W-1];
      den_neg       = den_i[DIFF_W-1];
      an            = num_neg ? DIFF_W'(-num_i) : DIFF_W'(num_i);
      ad            = den_neg ? DIFF_W'(-den_i) : DIFF_W'(den_i);
      side_in.byp   = num_zero | den_zero;
      side_in.degen = num_zero & den_zero;
      side_in.neg   = num_neg ^ den_neg;
      if (num_zero) begin
         side_in.val = '0;
      end else if (num_neg) begin
         side_in.val = RIGHT_ANGLE_Q16;
      end else begin
         side_in.val = -RIGHT_ANGLE_Q16;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff      <= {{(NORM_W-DIFF_W){1'b0}}, ad};
      ay_ff      <= {{(NORM_W-DIFF_W){1'b0}}, an};
      side_ff[0] <= side_in;
      for (int k = 1; k < SIDE_DEPTH; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   pot_norm u_norm (
      .clock (clock),
      .x_i   (ax_ff),
      .y_i   (ay_ff),
      .x_o   (nx),
      .y_o   (ny)
   );

   pot_cordic u_cordic (
      .clock (clock),
      .x_i   (nx),
      .y_i   (ny),
      .z_o   (z)
   );

   // clamp to a quarter turn, round half up to q.16, apply sign
   always_comb begin
      if (z < 0) begin
         zc = '0;
      end else if (z > RIGHT_ANGLE_Q24) begin
         zc = RIGHT_ANGLE_Q24;
      end else begin
         zc = z;
      end
      zr  = (zc + ROUND_HALF) >>> 8;
      mag = zr[TILT_W-1:0];
      if (side_ff[SIDE_DEPTH-1].byp) begin
         tilt_in = side_ff[SIDE_DEPTH-1].val;
      end else if (side_ff[SIDE_DEPTH-1].neg) begin
         tilt_in = mag;
      end else begin
         tilt_in = -mag;
      end
   end

   always_ff @(posedge clock) begin
      tilt_ff  <= tilt_in;
      degen_ff <= side_ff[SIDE_DEPTH-1].degen;
   end

   assign tilt_o  = tilt_ff;
   assign degen_o = degen_ff;

endmodule

>>> rtl/core/pot_checker.sv
// port checker for the plane offset and tilt block, bound to the top level
// depends on pot_pkg and plane_offset_and_tilt_defines.svh
`include "plane_offset_and_tilt_defines.svh"

module pot_checker
   import pot_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input pot_rsp_type rsp_word
);

   logic tilt_ok;
   logic some_zero;
   logic word_taken;
   logic dut_word;
   logic has_id;
   logic degen_word;

   assign tilt_ok =
      ($signed(rsp_word.alpha_tilt) <= RIGHT_ANGLE_Q16) &&
      ($signed(rsp_word.alpha_tilt) >= -RIGHT_ANGLE_Q16) &&
      ($signed(rsp_word.beta_tilt) <= RIGHT_ANGLE_Q16) &&
      ($signed(rsp_word.beta_tilt) >= -RIGHT_ANGLE_Q16) &&
      ($signed(rsp_word.gamma_tilt) <= RIGHT_ANGLE_Q16) &&
      ($signed(rsp_word.gamma_tilt) >= -RIGHT_ANGLE_Q16);

   assign some_zero = (rsp_word.alpha_tilt == '0) || (rsp_word.beta_tilt == '0) ||
                      (rsp_word.gamma_tilt == '0);

   assign word_taken = start && !busy;
   assign dut_word   = rsp_strobe && rsp_word.is_dut;
   assign has_id     = (rsp_word.sensor_id != -9'sd1);
   assign degen_word = rsp_strobe && rsp_word.degenerate;

   `POT_ASSERT_IMPL(a_no_phantom, rsp_strobe, $past(word_taken, PIPE_LATENCY), "no word in")
   `POT_ASSERT_IMPL(a_tilt_range, rsp_strobe, tilt_ok, "tilt beyond a quarter turn")
   `POT_ASSERT_IMPL(a_dut_has_id, dut_word, has_id, "dut plane without sensor id")
   `POT_ASSERT_IMPL(a_degen_zero, degen_word, some_zero, "degenerate word, no zero tilt")

endmodule

bind plane_offset_and_tilt pot_checker u_pot_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);
